/* rtl/core/homogeneous_point_transform_unit_macros.svh */
// Assertion macros for the point transform unit checker.
// Included by the checker file only.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH
// Same-cycle implication checked on every clock edge outside reset.
`define HPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: same-cycle implication failed");
// Next-cycle implication checked on every clock edge outside reset.
`define HPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: next-cycle implication failed");
`endif

/* rtl/core/hpt_pkg.sv */
// Shared types and constants for the homogeneous point transform unit.
// No dependencies.
package hpt_pkg;
	localparam int COORD_WIDTH = 16;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_POINT = 1'b1;

	typedef struct packed {
		logic operation;
		logic [3:0] coef_index;
		logic signed [31:0] coef_value;
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic [31:0] point_color;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic [31:0] out_color;
		logic w_was_zero;
	} out_item_t;
endpackage

/* rtl/core/hpt_divider.sv */
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// No dependencies.
module hpt_divider #(
	parameter int W = 32,
	parameter int TAG_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic signed [W-1:0] num,
	input logic signed [W-1:0] den,
	input logic [TAG_W-1:0] tag_in,
	output logic out_valid,
	output logic signed [W-1:0] quot,
	output logic [TAG_W-1:0] tag_out
);
	// Unsigned magnitudes are W+1 bits wide so that -2^(W-1) fits.
	localparam int M = W + 1;
	logic [M-1:0] rem_q [0:M];
	logic [M-1:0] qt_q [0:M];
	logic [M-1:0] dv_q [0:M];
	logic neg_q [0:M];
	logic [TAG_W-1:0] tag_q [0:M];
	logic vld_q [0:M];
	logic [M-1:0] qmag;
	logic signed [M:0] qs;

	always_comb begin
		rem_q[0] = '0;
		qt_q[0] = num[W-1] ? M'(-{num[W-1], num}) : M'({1'b0, num});
		dv_q[0] = den[W-1] ? M'(-{den[W-1], den}) : M'({1'b0, den});
		neg_q[0] = num[W-1] ^ den[W-1];
		tag_q[0] = tag_in;
		vld_q[0] = in_valid;
	end

	for (genvar i = 0; i < M; i++) begin : g_st
		logic [M:0] trial;
		logic [M-1:0] r_shift;
		assign r_shift = {rem_q[i][M-2:0], qt_q[i][M-1]};
		assign trial = {1'b0, r_shift} - {1'b0, dv_q[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (adv) begin
				vld_q[i+1] <= vld_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i+1] <= trial[M] ? r_shift : trial[M-1:0];
				qt_q[i+1] <= {qt_q[i][M-2:0], ~trial[M]};
				dv_q[i+1] <= dv_q[i];
				neg_q[i+1] <= neg_q[i];
				tag_q[i+1] <= tag_q[i];
			end
		end
	end

	always_comb begin
		qmag = qt_q[M];
		qs = neg_q[M] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		// Saturate the single overflow case of most negative over minus one.
		if (qs > $signed((M+1)'(2**(W-1) - 1))) begin
			quot = {1'b0, {(W-1){1'b1}}};
		end else begin
			quot = qs[W-1:0];
		end
	end
	assign out_valid = vld_q[M];
	assign tag_out = tag_q[M];
endmodule

/* rtl/core/hpt_column.sv */
// One column of the transform: three products, sum, truncation, saturation.
// No dependencies.
module hpt_column #(
	parameter int COORD_WIDTH = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input logic clk,
	input logic adv,
	input logic signed [COORD_WIDTH-1:0] x,
	input logic signed [COORD_WIDTH-1:0] y,
	input logic signed [COORD_WIDTH-1:0] z,
	input logic signed [31:0] c0,
	input logic signed [31:0] c1,
	input logic signed [31:0] c2,
	input logic signed [31:0] c3,
	output logic signed [31:0] result
);
	localparam int PW = COORD_WIDTH + 32;
	localparam int SW = PW + 3;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [31:0] c3_s1;
	logic signed [SW-1:0] sum_s2;
	logic signed [SW-1:0] ip;
	logic signed [SW-1:0] sum_c;
	logic fr;

	assign sum_c = SW'(px_s1) + SW'(py_s1) + SW'(pz_s1) + SW'(c3_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= PW'(x) * PW'(c0);
			py_s1 <= PW'(y) * PW'(c1);
			pz_s1 <= PW'(z) * PW'(c2);
			c3_s1 <= c3;
			sum_s2 <= sum_c;
		end
	end

	// Truncate toward zero, then clamp.
	always_comb begin
		fr = |sum_s2[COEF_FRAC_BITS-1:0];
		ip = (sum_s2 >>> COEF_FRAC_BITS) + $signed(SW'(sum_s2[SW-1] && fr));
		if (ip > SW'(64'sd2147483647)) begin
			result = 32'sh7fffffff;
		end else if (ip < -SW'(64'sd2147483648)) begin
			result = 32'sh80000000;
		end else begin
			result = ip[31:0];
		end
	end
endmodule

/* rtl/core/homogeneous_point_transform_unit.sv */
// Top level of the homogeneous point transform unit.
// Depends on hpt_pkg, hpt_column and hpt_divider.
//
// Usage:
//  - One input channel (in_valid/in_ready/in_data) carries both coefficient
//    writes (operation 0) and points (operation 1). A write stores coef_value
//    at coef_index and makes no result; a later point sees the new value.
//  - One output channel (out_valid/out_ready/out_data) carries one result per
//    point: x, y, z divided by w (truncating), w itself, color, and a flag when
//    w was zero and no division took place.
//  - Throughput: one item per cycle while the receiver does not stall. A point
//    passes from the accepting edge to the edge that raises out_valid through
//    the multiply, sum and saturate stages (3), the 33-stage restoring divider
//    and the output register, the first of them loaded at the accepting edge.
//  - The whole pipeline advances together; when the receiver stalls with a
//    result waiting, every stage holds, nothing drops, and in_ready goes low.
//  - Reset clears the coefficient table to zero and all valid bits.
module homogeneous_point_transform_unit #(
	parameter int COEF_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hpt_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output hpt_pkg::out_item_t out_data
);
	localparam int TAG_W = 32 + 32 + 1;
	logic [31:0] coef_q [0:15];
	logic adv;
	logic v_s1, v_s2, v_s3;
	logic [31:0] col_s1, col_s2;
	logic signed [31:0] r [0:3];
	logic signed [31:0] rw_s3;
	logic signed [31:0] rx_s3, ry_s3, rz_s3;
	logic [31:0] col_s3;
	logic [TAG_W-1:0] tag_in, tag_x;
	logic dv_x;
	logic signed [31:0] qx, qy, qz;
	logic out_v_q;
	hpt_pkg::out_item_t out_q;
	logic wz;
	logic signed [31:0] wv;
	logic [31:0] cv;
	logic signed [31:0] dw;

	// Advance whenever the output register is free or being drained.
	assign adv = !out_v_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) coef_q[i] <= '0;
		end else if (in_valid && in_ready && in_data.operation == hpt_pkg::OP_WRITE) begin
			coef_q[in_data.coef_index] <= in_data.coef_value;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_col
		hpt_column #(.COORD_WIDTH(hpt_pkg::COORD_WIDTH),
			.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_col (
			.clk(clk), .adv(adv),
			.x(in_data.point_x),
			.y(in_data.point_y),
			.z(in_data.point_z),
			.c0(coef_q[c]), .c1(coef_q[4+c]), .c2(coef_q[8+c]), .c3(coef_q[12+c]),
			.result(r[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_data.operation == hpt_pkg::OP_POINT;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= in_data.point_color;
			col_s2 <= col_s1;
			col_s3 <= col_s2;
			rx_s3 <= r[0];
			ry_s3 <= r[1];
			rz_s3 <= r[2];
			rw_s3 <= r[3];
		end
	end

	// Divide by one when w is zero so the undivided value passes through.
	assign dw = (rw_s3 == 0) ? 32'sd1 : rw_s3;
	assign tag_in = {rw_s3, col_s3, rw_s3 == 0};

	hpt_divider #(.W(32), .TAG_W(TAG_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s3),
		.num(rx_s3), .den(dw), .tag_in(tag_in),
		.out_valid(dv_x), .quot(qx), .tag_out(tag_x)
	);
	hpt_divider #(.W(32), .TAG_W(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(1'b0),
		.num(ry_s3), .den(dw), .tag_in(1'b0),
		.out_valid(), .quot(qy), .tag_out()
	);
	hpt_divider #(.W(32), .TAG_W(1)) u_div_z (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(1'b0),
		.num(rz_s3), .den(dw), .tag_in(1'b0),
		.out_valid(), .quot(qz), .tag_out()
	);

	assign wv = tag_x[TAG_W-1 -: 32];
	assign cv = tag_x[32:1];
	assign wz = tag_x[0];

	// Output register; hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_x;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= '{out_x: qx, out_y: qy, out_z: qz, out_w: wv,
				out_color: cv, w_was_zero: wz};
		end
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;
endmodule

/* rtl/core/hpt_checker.sv */
// Port-level checker for the point transform unit, bound to the top level.
// Depends on hpt_pkg and the macros header.
`include "homogeneous_point_transform_unit_macros.svh"
module hpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input hpt_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input hpt_pkg::out_item_t out_data
);
	`HPT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`HPT_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`HPT_ASSERT_IMP(a_stall_block, clk, arst_n, out_valid && !out_ready, !in_ready)
	`HPT_ASSERT_IMP(a_wz_w, clk, arst_n, out_valid && out_data.w_was_zero, out_data.out_w == 0)
endmodule

bind homogeneous_point_transform_unit hpt_checker u_hpt_checker (.*);

/* tb/sv/tb_top.sv */
// Testbench for the homogeneous point transform unit: loads coefficients,
// streams points and checks each result against an in-bench predictor.
// Depends on hpt_pkg and homogeneous_point_transform_unit.
module tb_top;
	localparam int FRAC = 16;
	localparam int DRAIN_CYCLES = 60;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	hpt_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	hpt_pkg::out_item_t out_data;

	// Predictor copy of the coefficient table.
	logic signed [31:0] coef_table [16];
	hpt_pkg::out_item_t pending_results [$];
	int error_count = 0;
	int idle_cycles = 0;
	bit stimulus_done;

	homogeneous_point_transform_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap length: mostly zero or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Saturate a wide value to signed 32 bits.
	function automatic logic signed [31:0] clamp32(logic signed [95:0] v);
		if (v > 96'sd2147483647)
			return 32'sh7fffffff;
		if (v < -96'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Exact fixed-point column sum, truncated toward zero, then saturated.
	function automatic logic signed [31:0] column_result(logic signed [15:0] px,
			logic signed [15:0] py, logic signed [15:0] pz, int col);
		logic signed [95:0] acc;
		logic signed [95:0] whole;
		acc = 96'(px) * 96'(coef_table[col]) + 96'(py) * 96'(coef_table[4 + col])
			+ 96'(pz) * 96'(coef_table[8 + col]) + 96'(coef_table[12 + col]);
		whole = acc >>> FRAC;
		// Arithmetic shift floors; bump negative sums with a fraction.
		if (acc < 0 && acc[FRAC-1:0] != '0)
			whole = whole + 1;
		return clamp32(whole);
	endfunction

	function automatic logic signed [31:0] div_trunc(logic signed [31:0] n,
			logic signed [31:0] d);
		logic signed [63:0] q;
		q = 64'(n) / 64'(d);
		return clamp32(96'(q));
	endfunction

	// Apply one accepted item to the predictor and queue any result.
	function automatic void predict_item(hpt_pkg::in_item_t it);
		hpt_pkg::out_item_t r;
		if (it.operation == hpt_pkg::OP_WRITE) begin
			coef_table[it.coef_index] = it.coef_value;
			return;
		end
		r.out_x = column_result(it.point_x, it.point_y, it.point_z, 0);
		r.out_y = column_result(it.point_x, it.point_y, it.point_z, 1);
		r.out_z = column_result(it.point_x, it.point_y, it.point_z, 2);
		r.out_w = column_result(it.point_x, it.point_y, it.point_z, 3);
		r.out_color = it.point_color;
		r.w_was_zero = (r.out_w == 0);
		if (!r.w_was_zero) begin
			r.out_x = div_trunc(r.out_x, r.out_w);
			r.out_y = div_trunc(r.out_y, r.out_w);
			r.out_z = div_trunc(r.out_z, r.out_w);
		end
		pending_results.push_back(r);
	endfunction

	// Drive one item; hold valid and payload until the transfer happens.
	// Valid stays high after the transfer so a following item can go at once;
	// drop it before a gap.
	task automatic send_item(hpt_pkg::in_item_t it, bit allow_gap = 1);
		int gap;
		gap = allow_gap ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		predict_item(it);
	endtask

	function automatic hpt_pkg::in_item_t write_item(int idx, logic signed [31:0] v);
		hpt_pkg::in_item_t it;
		it = '0;
		it.operation = hpt_pkg::OP_WRITE;
		it.coef_index = idx[3:0];
		it.coef_value = v;
		// Unused point fields carry noise; the block ignores them.
		it.point_x = 16'($urandom);
		it.point_color = $urandom;
		return it;
	endfunction

	function automatic hpt_pkg::in_item_t point_item(logic signed [15:0] px,
			logic signed [15:0] py, logic signed [15:0] pz, logic [31:0] color);
		hpt_pkg::in_item_t it;
		it = '0;
		it.operation = hpt_pkg::OP_POINT;
		it.coef_index = 4'($urandom);
		it.coef_value = $urandom;
		it.point_x = px;
		it.point_y = py;
		it.point_z = pz;
		it.point_color = color;
		return it;
	endfunction

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 20) - 10);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return ($urandom_range(0, 8) - 4) <<< FRAC;
			4: return $urandom_range(0, 1) ? 32'sh00010000 : 32'shffff0000;
			default: return $urandom;
		endcase
	endfunction

	// Hold off until every outstanding result has been checked.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Directed: identity matrix, then extremes of coordinates and color.
	task automatic test_identity_and_extremes();
		for (int i = 0; i < 16; i++)
			send_item(write_item(i, (i % 5 == 0) ? 32'sh00010000 : 32'sh0));
		send_item(point_item(16'sh7fff, 16'sh8000, 16'sh0001, 32'hffffffff));
		send_item(point_item(16'sh8000, 16'sh7fff, 16'shffff, 32'h00000000));
		send_item(point_item(16'sh0000, 16'sh0000, 16'sh0000, 32'h5a5aa5a5));
	endtask

	// Directed: zero w, sum saturation and the -2^31 / -1 overflow case.
	task automatic test_special_cases();
		wait_drained();
		// Zero w: clear column 3 entirely.
		send_item(write_item(15, 0));
		send_item(point_item(16'sh1234, 16'shedcb, 16'sh0042, 32'h01234567));
		// Saturating sums: huge coefficients in column 0, w = -1.
		send_item(write_item(0, 32'sh7fffffff));
		send_item(write_item(4, 32'sh7fffffff));
		send_item(write_item(15, 32'shffff0000));
		send_item(point_item(16'sh7fff, 16'sh7fff, 16'sh0000, 32'hdeadbeef));
		send_item(point_item(16'sh8000, 16'sh8000, 16'sh0000, 32'h0badf00d));
		// Negative fraction truncates toward zero: w = -0.5 -> 0.
		send_item(write_item(15, 32'shffff8000));
		send_item(point_item(-16'sd3, 16'sd5, 16'sd7, 32'h11111111));
		send_item(write_item(0, 32'sh80000000));
		send_item(write_item(15, 32'sh7fffffff));
		send_item(point_item(16'sh7fff, 16'sh8000, 16'sh7fff, 32'h80000001));
	endtask

	// Random: mostly points under a varied matrix, some coefficient reloads.
	task automatic test_random_stream(int count);
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				wait_drained();
			if ($urandom_range(0, 99) < 20) begin
				send_item(write_item($urandom_range(0, 15), rand_coef()), n % 40 >= 10);
			end else begin
				send_item(point_item(rand_coord(), rand_coord(), rand_coord(), $urandom),
					n % 40 >= 10);
			end
		end
	endtask

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		hpt_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.out_x !== want.out_x) begin
					$display("%0t: out_x expected %0d actual %0d", $time, want.out_x,
						out_data.out_x);
					error_count++;
				end
				if (out_data.out_y !== want.out_y) begin
					$display("%0t: out_y expected %0d actual %0d", $time, want.out_y,
						out_data.out_y);
					error_count++;
				end
				if (out_data.out_z !== want.out_z) begin
					$display("%0t: out_z expected %0d actual %0d", $time, want.out_z,
						out_data.out_z);
					error_count++;
				end
				if (out_data.out_w !== want.out_w) begin
					$display("%0t: out_w expected %0d actual %0d", $time, want.out_w,
						out_data.out_w);
					error_count++;
				end
				if (out_data.out_color !== want.out_color) begin
					$display("%0t: out_color expected %h actual %h", $time,
						want.out_color, out_data.out_color);
					error_count++;
				end
				if (out_data.w_was_zero !== want.w_was_zero) begin
					$display("%0t: w_was_zero expected %b actual %b", $time,
						want.w_was_zero, out_data.w_was_zero);
					error_count++;
				end
			end
		end
	end

	// Receiver stalls at random, with quiet stretches of no stall.
	always @(posedge clk) begin
		int hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (($time / 3000) % 3 != 0)
				hold = pick_gap();
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || stimulus_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int drain;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		stimulus_done = 1'b0;
		for (int i = 0; i < 16; i++)
			coef_table[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_and_extremes();
		test_special_cases();
		test_random_stream(420);
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
		drain = 0;
		while (pending_results.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
